### hw/rtl/bba_pkg.sv
`timescale 1ns / 1ps

package bba_pkg;

  // Geometry defaults
  localparam int INDEX_BITS_DEF = 16;
  localparam int BUCKET_BYTES   = 16;
  localparam int BUCKET_SHIFT   = $clog2(BUCKET_BYTES);

  // Free map words hold one bit per order-aligned slot
  localparam int WORD_BITS = 64;
  localparam int BIT_W     = $clog2(WORD_BITS);

  // Fixed field widths
  localparam int BYTES_W = 17;
  localparam int USE_W   = 16;

  // Request modes
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_BAD = 2'd1,
    ST_OOM = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SCAN_RD,
    S_SCAN_LD,
    S_PICK,
    S_SCORE,
    S_SCAN_END,
    S_RMW_RD,
    S_RMW_WR,
    S_DONE
  } state_e;

  typedef struct packed {
    logic    clr_step;
    logic    load_req;
    logic    start_scan;
    logic    scan_rd;
    logic    scan_ld;
    logic    next_word;
    logic    pick;
    logic    score;
    logic    commit_alloc;
    logic    start_free;
    logic    rmw_rd;
    logic    rmw_wr;
    logic    res_set;
    status_e res_code;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_free;
    logic bad_size;
    logic bad_index;
    logic no_order;
    logic word_zero;
    logic last_word;
    logic found;
    logic first;
    logic own_set;
    logic merge;
    logic more_split;
    logic out_free;
  } dp_stat_t;

  // Map words used by order k
  function automatic int words_of(int ib, int k);
    if (k <= ib - 6) begin
      return 1 << (ib - 6 - k);
    end else begin
      return 1;
    end
  endfunction

  // First map word of order k
  function automatic int base_of(int ib, int k);
    if (k <= ib - 6) begin
      return (1 << (ib - 5)) - ((1 << (ib - 5)) >> k);
    end else begin
      return (1 << (ib - 5)) - 2 + k - (ib - 6);
    end
  endfunction

  // Total map words over orders 0 .. ib
  function automatic int map_depth(int ib);
    return base_of(ib, ib + 1);
  endfunction

endpackage

### hw/rtl/bba_ram.sv
`timescale 1ns / 1ps

module bba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2053
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/bba_ctrl.sv
`timescale 1ns / 1ps

module bba_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output bba_pkg::cmd_t     cmd_o,
  input  bba_pkg::dp_stat_t stat_i
);
  import bba_pkg::*;

  state_e state_q, state_d;

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Sequence the datapath
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (stat_i.bad_size) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = ST_BAD;
          state_d        = S_DONE;
        end else if (!stat_i.is_free && stat_i.no_order) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = ST_OOM;
          state_d        = S_DONE;
        end else if (!stat_i.is_free) begin
          cmd_o.start_scan = 1'b1;
          state_d          = S_SCAN_RD;
        end else if (stat_i.bad_index) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = ST_BAD;
          state_d        = S_DONE;
        end else begin
          cmd_o.start_free = 1'b1;
          state_d          = S_RMW_RD;
        end
      end
      S_SCAN_RD: begin
        cmd_o.scan_rd = 1'b1;
        state_d       = S_SCAN_LD;
      end
      S_SCAN_LD: begin
        cmd_o.scan_ld = 1'b1;
        state_d       = S_PICK;
      end
      S_PICK: begin
        priority if (stat_i.word_zero && stat_i.last_word) begin
          state_d = S_SCAN_END;
        end else if (stat_i.word_zero) begin
          cmd_o.next_word = 1'b1;
          state_d         = S_SCAN_RD;
        end else begin
          cmd_o.pick = 1'b1;
          state_d    = S_SCORE;
        end
      end
      S_SCORE: begin
        cmd_o.score = 1'b1;
        state_d     = S_PICK;
      end
      S_SCAN_END: begin
        if (!stat_i.found) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = ST_OOM;
          state_d        = S_DONE;
        end else begin
          cmd_o.commit_alloc = 1'b1;
          state_d            = S_RMW_RD;
        end
      end
      S_RMW_RD: begin
        cmd_o.rmw_rd = 1'b1;
        state_d      = S_RMW_WR;
      end
      S_RMW_WR: begin
        priority if (stat_i.is_free && stat_i.first && stat_i.own_set) begin
          // double free: leave the map alone
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = ST_BAD;
          state_d        = S_DONE;
        end else if (stat_i.is_free) begin
          cmd_o.rmw_wr = 1'b1;
          state_d      = stat_i.merge ? S_RMW_RD : S_DONE;
        end else begin
          cmd_o.rmw_wr = 1'b1;
          state_d      = stat_i.more_split ? S_RMW_RD : S_DONE;
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_no_write_on_double_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RMW_WR && stat_i.is_free && stat_i.first && stat_i.own_set)
      |-> !cmd_o.rmw_wr)
    else $error("map written on a double free");

  a_stall_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> in_stall_o)
    else $error("request taken during map clear");
`endif

endmodule

### hw/rtl/bba_dp.sv
`timescale 1ns / 1ps

module bba_dp #(
  parameter int INDEX_BITS = bba_pkg::INDEX_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bba_pkg::cmd_t                 cmd_i,
  output bba_pkg::dp_stat_t             stat_o,
  input  logic                          mode_i,
  input  logic [bba_pkg::BYTES_W-1:0]   byte_count_i,
  input  logic [INDEX_BITS-1:0]         block_index_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [INDEX_BITS-1:0]         granted_index_o,
  output logic [1:0]                    status_o,
  output logic [bba_pkg::USE_W-1:0]     buckets_in_use_o,
  output logic [bba_pkg::USE_W-1:0]     blocks_in_use_o
);
  import bba_pkg::*;

  localparam int ORD_W     = $clog2(INDEX_BITS + 1);
  localparam int MAP_DEPTH = map_depth(INDEX_BITS);
  localparam int ADDR_W    = $clog2(MAP_DEPTH);
  localparam int SCAN_W    = INDEX_BITS - BIT_W;
  localparam int SCORE_W   = INDEX_BITS + 1;
  localparam int POP_W     = $clog2(INDEX_BITS + 1);
  localparam int TZ_W      = $clog2(INDEX_BITS);
  localparam logic [31:0] SLOT_COUNT = 32'd1 << INDEX_BITS;

  // Request registers
  logic                  mode_q;
  logic                  bad_size_q;
  logic [ORD_W-1:0]      ord_q;
  logic [INDEX_BITS-1:0] idx_q;

  // Per-order free counts and usage counters
  logic [INDEX_BITS-1:0] cnt_q [INDEX_BITS+1];
  logic                  cnt_upd, cnt_inc;
  logic [USE_W-1:0]      used_buckets_q, used_blocks_q;

  // Scan state
  logic [ORD_W-1:0]      n_q;
  logic [SCAN_W-1:0]     scan_w_q;
  logic [WORD_BITS-1:0]  word_q;
  logic [INDEX_BITS-1:0] cand_q, best_q;
  logic [SCORE_W-1:0]    best_score_q;
  logic                  found_q;

  // Read-modify-write state
  logic [ORD_W-1:0]      cur_ord_q;
  logic [INDEX_BITS-1:0] cur_idx_q;
  logic                  first_q, take_q;

  // Result and output registers
  status_e               res_status_q;
  logic [INDEX_BITS-1:0] res_granted_q;
  logic                  out_valid_q;
  logic [INDEX_BITS-1:0] out_granted_q;
  status_e               out_status_q;
  logic [USE_W-1:0]      out_buckets_q, out_blocks_q;

  // Clear sweep
  logic [ADDR_W-1:0]     clr_addr_q;
  logic [WORD_BITS-1:0]  init_word;

  // Memory port
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0]  ram_wdata, ram_rdata;

  // Combinational helpers
  logic [BYTES_W-1:0]    bkt_m1, bkt_sh;
  logic [ORD_W-1:0]      ord_in;
  logic                  bad_size_in;
  logic [ORD_W-1:0]      srch_ord;
  logic                  srch_hit;
  logic [ADDR_W-1:0]     scan_addr, rmw_addr;
  logic [BIT_W-1:0]      low_b;
  logic [INDEX_BITS-1:0] sc_m;
  logic [POP_W-1:0]      sc_pop;
  logic [TZ_W-1:0]       sc_tz;
  logic [SCORE_W-1:0]    sc_val;
  logic [INDEX_BITS-1:0] rmw_slot;
  logic [BIT_W-1:0]      rmw_bit, bud_bit;
  logic                  own_bit, bud_set, merge, more_split;
  logic [WORD_BITS-1:0]  wr_data;

  // Decode size into order
  always_comb begin
    bkt_m1 = byte_count_i - BYTES_W'(1);
    bkt_sh = bkt_m1 >> BUCKET_SHIFT;
    ord_in = '0;
    for (int i = 0; i < BYTES_W; i++) begin
      if (bkt_sh[i]) begin
        ord_in = ORD_W'(i + 1);
      end
    end
    bad_size_in = (byte_count_i == '0) || (32'(byte_count_i) >= SLOT_COUNT);
  end

  // Find lowest non-empty order at or above the request order
  always_comb begin
    srch_ord = '0;
    srch_hit = 1'b0;
    for (int k = INDEX_BITS; k >= 0; k--) begin
      if (cnt_q[k] != '0 && ORD_W'(k) >= ord_q) begin
        srch_hit = 1'b1;
        srch_ord = ORD_W'(k);
      end
    end
  end

  // Scan addressing and lowest free slot in the current word
  always_comb begin
    scan_addr = ADDR_W'(base_of(INDEX_BITS, int'(n_q))) + ADDR_W'(scan_w_q);
    low_b     = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (word_q[b]) begin
        low_b = BIT_W'(b);
      end
    end
  end

  // Score the candidate: m - popcount(m) + 2^ctz(m)
  always_comb begin
    sc_m   = '0 - cand_q;
    sc_pop = '0;
    sc_tz  = '0;
    for (int i = 0; i < INDEX_BITS; i++) begin
      sc_pop = sc_pop + POP_W'(sc_m[i]);
    end
    for (int i = INDEX_BITS - 1; i >= 0; i--) begin
      if (sc_m[i]) begin
        sc_tz = TZ_W'(i);
      end
    end
    sc_val = SCORE_W'(sc_m) - SCORE_W'(sc_pop) + (SCORE_W'(1) << sc_tz);
  end

  // Map word update for take, split and free
  always_comb begin
    rmw_slot   = cur_idx_q >> cur_ord_q;
    rmw_addr   = ADDR_W'(base_of(INDEX_BITS, int'(cur_ord_q)))
               + ADDR_W'(rmw_slot >> BIT_W);
    rmw_bit    = rmw_slot[BIT_W-1:0];
    bud_bit    = rmw_bit ^ BIT_W'(1);
    own_bit    = ram_rdata[rmw_bit];
    bud_set    = ram_rdata[bud_bit];
    merge      = (cur_ord_q < ORD_W'(INDEX_BITS)) && bud_set;
    more_split = cur_ord_q > ord_q;
    wr_data    = ram_rdata;
    cnt_upd    = 1'b0;
    cnt_inc    = 1'b0;
    priority if (mode_q == MODE_FREE && merge) begin
      wr_data[bud_bit] = 1'b0;
      cnt_upd          = 1'b1;
    end else if (mode_q == MODE_FREE || !take_q) begin
      wr_data[rmw_bit] = 1'b1;
      cnt_upd          = !own_bit;
      cnt_inc          = 1'b1;
    end else begin
      wr_data[rmw_bit] = 1'b0;
      cnt_upd          = own_bit;
    end
  end

  // Reset image of the map: slot 1 free at every order below the top
  always_comb begin
    init_word = '0;
    for (int k = 0; k < INDEX_BITS; k++) begin
      if (clr_addr_q == ADDR_W'(base_of(INDEX_BITS, k))) begin
        init_word[1] = 1'b1;
      end
    end
  end

  // Memory port muxing
  always_comb begin
    ram_we    = cmd_i.clr_step | cmd_i.rmw_wr;
    ram_waddr = cmd_i.clr_step ? clr_addr_q : rmw_addr;
    ram_wdata = cmd_i.clr_step ? init_word : wr_data;
    ram_raddr = cmd_i.scan_rd ? scan_addr : rmw_addr;
  end

  bba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Advance clear sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_addr_q <= clr_addr_q + ADDR_W'(1);
    end
  end

  // Hold per-order free counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= INDEX_BITS; k++) begin
        cnt_q[k] <= (k < INDEX_BITS) ? INDEX_BITS'(1) : '0;
      end
    end else if (cmd_i.rmw_wr && cnt_upd) begin
      for (int k = 0; k <= INDEX_BITS; k++) begin
        if (cur_ord_q == ORD_W'(k)) begin
          cnt_q[k] <= cnt_inc ? cnt_q[k] + INDEX_BITS'(1) : cnt_q[k] - INDEX_BITS'(1);
        end
      end
    end
  end

  // Track buckets and blocks in use
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_buckets_q <= '0;
      used_blocks_q  <= '0;
    end else if (cmd_i.commit_alloc) begin
      used_buckets_q <= used_buckets_q + (USE_W'(1) << ord_q);
      used_blocks_q  <= used_blocks_q + USE_W'(1);
    end else if (cmd_i.rmw_wr && mode_q == MODE_FREE && first_q) begin
      used_buckets_q <= used_buckets_q - (USE_W'(1) << ord_q);
      used_blocks_q  <= used_blocks_q - USE_W'(1);
    end
  end

  // Latch request
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      mode_q     <= mode_i;
      bad_size_q <= bad_size_in;
      ord_q      <= ord_in;
      idx_q      <= block_index_i;
    end
  end

  // Walk free slots of the chosen order
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_scan) begin
      n_q      <= srch_ord;
      scan_w_q <= '0;
    end else if (cmd_i.next_word) begin
      scan_w_q <= scan_w_q + SCAN_W'(1);
    end
    if (cmd_i.scan_ld) begin
      word_q <= ram_rdata;
    end else if (cmd_i.pick) begin
      word_q <= word_q & (word_q - WORD_BITS'(1));
      cand_q <= {scan_w_q, low_b} << n_q;
    end
  end

  // Keep best score; ties keep the lower index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.start_scan) begin
      found_q <= 1'b0;
    end else if (cmd_i.score && cand_q != '0 && (!found_q || sc_val > best_score_q)) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.score && cand_q != '0 && (!found_q || sc_val > best_score_q)) begin
      best_q       <= cand_q;
      best_score_q <= sc_val;
    end
  end

  // Step through take, split and merge levels
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit_alloc) begin
      cur_ord_q <= n_q;
      cur_idx_q <= best_q;
      take_q    <= 1'b1;
    end else if (cmd_i.start_free) begin
      cur_ord_q <= ord_q;
      cur_idx_q <= idx_q;
      first_q   <= 1'b1;
    end else if (cmd_i.rmw_wr) begin
      first_q <= 1'b0;
      if (mode_q == MODE_FREE) begin
        if (merge) begin
          cur_idx_q <= cur_idx_q & ~(INDEX_BITS'(1) << cur_ord_q);
          cur_ord_q <= cur_ord_q + ORD_W'(1);
        end
      end else if (more_split) begin
        take_q    <= 1'b0;
        cur_ord_q <= cur_ord_q - ORD_W'(1);
        cur_idx_q <= best_q | (INDEX_BITS'(1) << (cur_ord_q - ORD_W'(1)));
      end
    end
  end

  // Build result
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      res_status_q  <= ST_OK;
      res_granted_q <= '0;
    end else if (cmd_i.res_set) begin
      res_status_q <= cmd_i.res_code;
    end else if (cmd_i.commit_alloc) begin
      res_granted_q <= best_q;
    end
  end

  // Output register: load, then drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_granted_q <= res_granted_q;
      out_status_q  <= res_status_q;
      out_buckets_q <= used_buckets_q;
      out_blocks_q  <= used_blocks_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign granted_index_o  = out_granted_q;
  assign status_o         = out_status_q;
  assign buckets_in_use_o = out_buckets_q;
  assign blocks_in_use_o  = out_blocks_q;

  // Status to the controller
  always_comb begin
    stat_o.clr_last   = clr_addr_q == ADDR_W'(MAP_DEPTH - 1);
    stat_o.is_free    = mode_q == MODE_FREE;
    stat_o.bad_size   = bad_size_q;
    stat_o.bad_index  = (idx_q == '0)
                      || ((idx_q & ~({INDEX_BITS{1'b1}} << ord_q)) != '0);
    stat_o.no_order   = !srch_hit;
    stat_o.word_zero  = word_q == '0;
    stat_o.last_word  = scan_w_q == SCAN_W'(words_of(INDEX_BITS, int'(n_q)) - 1);
    stat_o.found      = found_q;
    stat_o.first      = first_q;
    stat_o.own_set    = own_bit;
    stat_o.merge      = merge;
    stat_o.more_split = more_split;
    stat_o.out_free   = !out_valid_q || !out_stall_i;
  end

`ifndef SYNTHESIS
  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("held result overwritten");

  a_best_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> best_q != '0)
    else $error("bucket zero selected");
`endif

endmodule

### hw/rtl/buddy_block_allocator.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_stall_o    mode_i, byte_count_i, block_index_i
// out      output     out_valid_o / out_stall_i  granted_index_o, status_o,
//                                                buckets_in_use_o, blocks_in_use_o
//
// One request at a time; all map access goes through one single-port-pair memory.
// Allocate: each map word of the chosen order is read (2^(INDEX_BITS-6) words at
//   order 0, one word above order INDEX_BITS-6), each free block in it is scored, and
//   the best block is split level by level. Free: merged level by level with free buddies.
// After reset all 2^(INDEX_BITS-5)+5 map words (2053 by default) are swept,
//   with in_stall_o high. A stalled result stays in the output register while the
//   next request is worked on; it waits only for that register.

module buddy_block_allocator #(
  parameter int INDEX_BITS = bba_pkg::INDEX_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        mode_i,
  input  logic [bba_pkg::BYTES_W-1:0] byte_count_i,
  input  logic [INDEX_BITS-1:0]       block_index_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [INDEX_BITS-1:0]       granted_index_o,
  output logic [1:0]                  status_o,
  output logic [bba_pkg::USE_W-1:0]   buckets_in_use_o,
  output logic [bba_pkg::USE_W-1:0]   blocks_in_use_o
);
  import bba_pkg::*;

  cmd_t     cmd;
  dp_stat_t stat;

  bba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  bba_dp #(
    .INDEX_BITS (INDEX_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .mode_i           (mode_i),
    .byte_count_i     (byte_count_i),
    .block_index_i    (block_index_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .granted_index_o  (granted_index_o),
    .status_o         (status_o),
    .buckets_in_use_o (buckets_in_use_o),
    .blocks_in_use_o  (blocks_in_use_o)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second request taken while one is in flight");
`endif

endmodule
